// ===== src/frustum_plane_extract_macros.svh =====
// assertion macros used by the checker file
`ifndef FRUSTUM_PLANE_EXTRACT_MACROS_SVH
`define FRUSTUM_PLANE_EXTRACT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fpe_pkg.sv =====
// shared types and constants for the frustum plane extractor
package fpe_pkg;

    localparam int ElemW      = 32;
    localparam int CompW      = 33;
    localparam int QueueDepth = 2;

    localparam logic [2:0] PlaneTop    = 3'd0;
    localparam logic [2:0] PlaneBottom = 3'd1;
    localparam logic [2:0] PlaneLeft   = 3'd2;
    localparam logic [2:0] PlaneRight  = 3'd3;
    localparam logic [2:0] PlaneNear   = 3'd4;
    localparam logic [2:0] PlaneFar    = 3'd5;

    typedef logic signed [CompW-1:0] t_comp;

    // one unnormalized plane on its way from front to back
    typedef struct packed {
        logic [2:0] idx;
        t_comp      a;
        t_comp      b;
        t_comp      c;
        t_comp      d;
    } t_plane_job;

endpackage

// ===== src/fpe_front.sv =====
// front end: collects matrix rows and issues the six raw plane requests
module fpe_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [31:0]       i_elem_x,
    input  logic signed [31:0]       i_elem_y,
    input  logic signed [31:0]       i_elem_z,
    input  logic signed [31:0]       i_elem_w,
    output logic                     o_job_valid,
    input  logic                     i_job_ready,
    output fpe_pkg::t_plane_job      o_job
);
    import fpe_pkg::*;

    logic signed [31:0] r_m [4][4];
    logic [1:0]         r_cnt;
    logic               r_emit;
    logic [2:0]         r_pidx;
    t_comp              comp [4];

    function automatic t_comp plane_comp(input logic [2:0] pidx,
                                         input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z,
                                         input logic signed [31:0] w);
        t_comp xs, ys, zs, ws, res;
        xs = t_comp'(x);
        ys = t_comp'(y);
        zs = t_comp'(z);
        ws = t_comp'(w);
        case (pidx)
            PlaneTop:    res = ws - ys;
            PlaneBottom: res = ws + ys;
            PlaneLeft:   res = ws + xs;
            PlaneRight:  res = ws - xs;
            PlaneNear:   res = zs;
            default:     res = ws - zs;
        endcase
        return res;
    endfunction

    assign o_ready     = !r_emit;
    assign o_job_valid = r_emit;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            comp[k] = plane_comp(r_pidx, r_m[k][0], r_m[k][1], r_m[k][2], r_m[k][3]);
        end
        o_job.idx = r_pidx;
        o_job.a   = comp[0];
        o_job.b   = comp[1];
        o_job.c   = comp[2];
        o_job.d   = comp[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_emit <= 1'b0;
            r_pidx <= PlaneTop;
        end else begin
            if (i_valid && o_ready) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_emit <= 1'b1;
                    r_pidx <= PlaneTop;
                end
            end
            if (o_job_valid && i_job_ready) begin
                if (r_pidx == PlaneFar) begin
                    r_emit <= 1'b0;
                end else begin
                    r_pidx <= r_pidx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_m[r_cnt][0] <= i_elem_x;
            r_m[r_cnt][1] <= i_elem_y;
            r_m[r_cnt][2] <= i_elem_z;
            r_m[r_cnt][3] <= i_elem_w;
        end
    end

endmodule

// ===== src/fpe_queue.sv =====
// small request queue between front and back
module fpe_queue #(
    parameter int DEPTH = fpe_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  fpe_pkg::t_plane_job i_push_data,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output fpe_pkg::t_plane_job o_pop_data
);
    import fpe_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    t_plane_job      r_mem [DEPTH];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [CntW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != CntW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LastPtr) ? '0 : r_wp + PtrW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == LastPtr) ? '0 : r_rp + PtrW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

// ===== src/fpe_back.sv =====
// back end: squared length, bit-serial root and divide, saturation, output register
module fpe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  fpe_pkg::t_plane_job i_job,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_plane_index,
    output logic signed [31:0]  o_plane_a,
    output logic signed [31:0]  o_plane_b,
    output logic signed [31:0]  o_plane_c,
    output logic signed [31:0]  o_plane_d,
    output logic                o_degenerate,
    output logic                o_last
);
    import fpe_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StSq   = 3'd1;
    localparam logic [2:0] StRoot = 3'd2;
    localparam logic [2:0] StLoad = 3'd3;
    localparam logic [2:0] StDiv  = 3'd4;
    localparam logic [2:0] StPost = 3'd5;

    logic [2:0]   r_st;
    t_plane_job   r_job;
    logic [1:0]   r_k;
    logic [65:0]  r_prod;
    logic [65:0]  r_sum;
    logic [99:0]  r_rad;
    logic [49:0]  r_root;
    logic [51:0]  r_rem;
    logic [6:0]   r_step;
    logic [64:0]  r_dvd;
    logic [50:0]  r_drem;
    logic [32:0]  r_q;
    logic         r_ovf;
    logic [31:0]  r_res [4];
    logic         r_deg;
    logic         r_o_valid;

    t_comp        cur;
    logic [32:0]  cur_mag;
    logic [65:0]  sq;
    logic [65:0]  sum_nx;
    logic [53:0]  rem_sh;
    logic [53:0]  trial;
    logic         rge;
    logic [53:0]  rem_diff;
    logic [51:0]  drem_sh;
    logic [51:0]  len_ext;
    logic         dge;
    logic [51:0]  drem_diff;
    logic [32:0]  q_nx;
    logic         ovf_nx;
    logic         big;
    logic [31:0]  res;
    logic         out_free;

    always_comb begin
        case (r_k)
            2'd0:    cur = r_job.a;
            2'd1:    cur = r_job.b;
            2'd2:    cur = r_job.c;
            default: cur = r_job.d;
        endcase
        cur_mag = cur[32] ? (~cur + 33'd1) : cur;
        sq      = cur_mag * cur_mag;
        sum_nx  = r_sum + r_prod;

        // one root digit per cycle
        rem_sh   = {r_rem, r_rad[99:98]};
        trial    = {2'b00, r_root, 2'b01};
        rge      = (rem_sh >= trial);
        rem_diff = rem_sh - trial;

        // one quotient bit per cycle
        drem_sh   = {r_drem, r_dvd[64]};
        len_ext   = {2'b00, r_root};
        dge       = (drem_sh >= len_ext);
        drem_diff = drem_sh - len_ext;
        q_nx      = {r_q[31:0], dge};
        ovf_nx    = r_ovf | r_q[32];

        big = ovf_nx || (q_nx > 33'h0_8000_0000);
        if (cur[32]) begin
            res = big ? 32'h8000_0000 : (~q_nx[31:0] + 32'd1);
        end else begin
            res = (big || q_nx[31]) ? 32'h7FFF_FFFF : q_nx[31:0];
        end
    end

    assign out_free    = !r_o_valid || i_ready;
    assign o_job_ready = (r_st == StIdle);
    assign o_valid     = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= StIdle;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && (r_st != StPost)) begin
                r_o_valid <= 1'b0;
            end
            case (r_st)
                StIdle: begin
                    if (i_job_valid) begin
                        r_st <= StSq;
                    end
                end
                StSq: begin
                    if (r_k == 2'd3) begin
                        r_st <= (sum_nx == '0) ? StPost : StRoot;
                    end
                end
                StRoot: begin
                    if (r_step == 7'd0) begin
                        r_st <= StLoad;
                    end
                end
                StLoad: begin
                    r_st <= StDiv;
                end
                StDiv: begin
                    if (r_step == 7'd0) begin
                        r_st <= (r_k == 2'd3) ? StPost : StLoad;
                    end
                end
                StPost: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_st      <= StIdle;
                    end
                end
                default: begin
                    r_st <= StIdle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            StIdle: begin
                r_job <= i_job;
                r_k   <= 2'd0;
                r_sum <= '0;
            end
            StSq: begin
                if (r_k != 2'd0) begin
                    r_sum <= sum_nx;
                end
                if (r_k != 2'd3) begin
                    r_prod <= sq;
                end
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_deg <= (sum_nx == '0);
                    for (int i = 0; i < 4; i++) begin
                        r_res[i] <= '0;
                    end
                    r_rad  <= {2'b00, sum_nx, 32'd0};
                    r_root <= '0;
                    r_rem  <= '0;
                    r_step <= 7'd49;
                end
            end
            StRoot: begin
                r_rad  <= {r_rad[97:0], 2'b00};
                r_root <= {r_root[48:0], rge};
                r_rem  <= rge ? rem_diff[51:0] : rem_sh[51:0];
                r_step <= r_step - 7'd1;
            end
            StLoad: begin
                r_dvd  <= {cur_mag, 32'd0};
                r_drem <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_step <= 7'd64;
            end
            StDiv: begin
                r_dvd  <= {r_dvd[63:0], 1'b0};
                r_drem <= dge ? drem_diff[50:0] : drem_sh[50:0];
                r_q    <= q_nx;
                r_ovf  <= ovf_nx;
                r_step <= r_step - 7'd1;
                if (r_step == 7'd0) begin
                    r_res[r_k] <= res;
                    r_k        <= r_k + 2'd1;
                end
            end
            StPost: begin
                if (out_free) begin
                    o_plane_index <= r_job.idx;
                    o_plane_a     <= r_res[0];
                    o_plane_b     <= r_res[1];
                    o_plane_c     <= r_res[2];
                    o_plane_d     <= r_res[3];
                    o_degenerate  <= r_deg;
                    o_last        <= (r_job.idx == PlaneFar);
                end
            end
            default: begin
                r_k <= 2'd0;
            end
        endcase
    end

endmodule

// ===== src/frustum_plane_extract.sv =====
// The block takes a projection matrix one row per request (x, y, z, w in Q16.16),
// rows 0 to 3 in order. Rows 0 to 2 are taken one per cycle and held; the fourth row
// makes the front issue six raw planes (top, bottom, left, right, near, far) into a
// short queue, and input stays stalled until all six are queued. The back normalizes
// one plane at a time on a shared bit-serial unit: the squared length, then the root,
// then the divide for each component in turn; that unit sets the rate. Results
// leave through an output register, so the next plane is worked on while one waits
// to be taken.
module frustum_plane_extract #(
    parameter int QUEUE_DEPTH = fpe_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_elem_x,
    input  logic signed [31:0]  i_elem_y,
    input  logic signed [31:0]  i_elem_z,
    input  logic signed [31:0]  i_elem_w,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_plane_index,
    output logic signed [31:0]  o_plane_a,
    output logic signed [31:0]  o_plane_b,
    output logic signed [31:0]  o_plane_c,
    output logic signed [31:0]  o_plane_d,
    output logic                o_degenerate,
    output logic                o_last
);
    import fpe_pkg::*;

    logic       front_valid;
    logic       front_ready;
    t_plane_job front_job;
    logic       back_valid;
    logic       back_ready;
    t_plane_job back_job;

    fpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_elem_x    (i_elem_x),
        .i_elem_y    (i_elem_y),
        .i_elem_z    (i_elem_z),
        .i_elem_w    (i_elem_w),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    fpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_job)
    );

    fpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (back_valid),
        .o_job_ready   (back_ready),
        .i_job         (back_job),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_plane_index (o_plane_index),
        .o_plane_a     (o_plane_a),
        .o_plane_b     (o_plane_b),
        .o_plane_c     (o_plane_c),
        .o_plane_d     (o_plane_d),
        .o_degenerate  (o_degenerate),
        .o_last        (o_last)
    );

endmodule

// ===== src/fpe_checker.sv =====
// port-level checks for the frustum plane extractor, bound to the top level
`include "frustum_plane_extract_macros.svh"

module fpe_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [2:0]         o_plane_index,
    input logic signed [31:0] o_plane_a,
    input logic signed [31:0] o_plane_b,
    input logic signed [31:0] o_plane_c,
    input logic signed [31:0] o_plane_d,
    input logic               o_degenerate,
    input logic               o_last
);
    import fpe_pkg::*;

    `FPE_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_plane_index) && $stable(o_plane_a) && $stable(o_plane_d), "result changed while stalled")
    `FPE_ASSERT_IMP(a_last_far, o_valid, o_last == (o_plane_index == PlaneFar), "last mark not on the far plane")
    `FPE_ASSERT_IMP(a_degen_zero, o_valid && o_degenerate, o_plane_a == 0 && o_plane_b == 0 && o_plane_c == 0 && o_plane_d == 0, "degenerate plane not zero")

endmodule

bind frustum_plane_extract fpe_port_checker u_fpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_plane_index (o_plane_index),
    .o_plane_a     (o_plane_a),
    .o_plane_b     (o_plane_b),
    .o_plane_c     (o_plane_c),
    .o_plane_d     (o_plane_d),
    .o_degenerate  (o_degenerate),
    .o_last        (o_last)
);
